// ===== rtl/core/att_pkg.sv =====
// shared constants, types and sine table builder for the audio test-tone generator
package att_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
    localparam int ADDR_SHIFT      = PHASE_BITS - 2 - TABLE_ADDR_BITS;
    localparam int SINE_BITS       = 23;
    localparam int AMP_BITS        = 23;
    localparam int PROD_BITS       = SINE_BITS + AMP_BITS;
    localparam int VAL_BITS        = AMP_BITS + 1;
    localparam int WORD_BITS       = 32;
    localparam int NARROW_BITS     = 16;
    localparam int WIDE_SHIFT      = WORD_BITS - VAL_BITS;
    localparam int STEP_BITS       = 32;
    localparam int CNT_BITS        = 16;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [SINE_BITS-1:0] FULL_SCALE = {SINE_BITS{1'b1}};
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 7;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_STEP    = 3'd0,
        REG_PERIOD_COUNT  = 3'd1,
        REG_HIGH_LIMIT    = 3'd2,
        REG_AMPLITUDE     = 3'd3,
        REG_UNSIGNED_MODE = 3'd4,
        REG_SQUARE_MODE   = 3'd5,
        REG_WIDE_SAMPLES  = 3'd6,
        REG_CHANNEL_MODE  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        CH_STEREO     = 2'd0,
        CH_LEFT_MUTE  = 2'd1,
        CH_RIGHT_MUTE = 2'd2,
        CH_MONO       = 2'd3
    } chan_mode_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] phase_step;
        logic [CNT_BITS-1:0]  period_count;
        logic [CNT_BITS-1:0]  high_limit;
        logic [AMP_BITS-1:0]  amplitude;
        logic                 unsigned_mode;
        logic                 square_mode;
        logic                 wide_samples;
        chan_mode_t           channel_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0] quad;
        logic       full_scale;
        logic       square_high;
    } stage_ctrl_t;

    typedef logic [SINE_BITS-1:0] sine_rom_t [TABLE_SIZE];

    // quarter-wave sine in q0.23 from a truncated fixed-point taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 0; k < TAYLOR_TERMS; k++)
            begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[k];
                if ((k % 2) == 0)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (64'(sum) + 64'd64) >> 7;
            if (v > 64'(FULL_SCALE))
            begin
                v = 64'(FULL_SCALE);
            end
            rom[i] = v[SINE_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/att_cfg_regs.sv =====
// configuration register bank
module att_cfg_regs
    import att_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PHASE_STEP:    cfg_next.phase_step    = cfg_data[STEP_BITS-1:0];
                REG_PERIOD_COUNT:  cfg_next.period_count  = cfg_data[CNT_BITS-1:0];
                REG_HIGH_LIMIT:    cfg_next.high_limit    = cfg_data[CNT_BITS-1:0];
                REG_AMPLITUDE:     cfg_next.amplitude     = cfg_data[AMP_BITS-1:0];
                REG_UNSIGNED_MODE: cfg_next.unsigned_mode = cfg_data[0];
                REG_SQUARE_MODE:   cfg_next.square_mode   = cfg_data[0];
                REG_WIDE_SAMPLES:  cfg_next.wide_samples  = cfg_data[0];
                REG_CHANNEL_MODE:  cfg_next.channel_mode  = chan_mode_t'(cfg_data[1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= STEP_BITS'(77913239);
            cfg_reg.period_count  <= CNT_BITS'(56);
            cfg_reg.high_limit    <= CNT_BITS'(27);
            cfg_reg.amplitude     <= AMP_BITS'(32767);
            cfg_reg.unsigned_mode <= 1'b0;
            cfg_reg.square_mode   <= 1'b0;
            cfg_reg.wide_samples  <= 1'b0;
            cfg_reg.channel_mode  <= CH_STEREO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/att_sine_rom.sv =====
// quarter-wave sine table with registered read
module att_sine_rom
    import att_pkg::*;
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [TABLE_ADDR_BITS-1:0] rd_addr,
    output logic [SINE_BITS-1:0]       rd_data
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [SINE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/att_phase_gen.sv =====
// phase accumulator, square period counter and table address stage
module att_phase_gen
    import att_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       load,
    input  logic                       s2_free,
    output logic                       s1_valid,
    output stage_ctrl_t                s1_ctrl,
    output logic                       rom_en,
    output logic [TABLE_ADDR_BITS-1:0] rom_addr
);

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [CNT_BITS-1:0]        counter_reg;
    logic [CNT_BITS-1:0]        counter_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    stage_ctrl_t                s1_ctrl_reg;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [TABLE_ADDR_BITS-1:0] addr_mirror;
    logic [CNT_BITS:0]          cnt_inc;
    logic                       s1_free;

    assign quad        = phase_reg[PHASE_BITS-1 -: 2];
    assign addr        = phase_reg[ADDR_SHIFT +: TABLE_ADDR_BITS];
    assign addr_mirror = '0 - addr;
    assign rom_addr    = quad[0] ? addr_mirror : addr;
    assign rom_en      = load;

    assign cnt_inc = {1'b0, counter_reg} + 1'b1;
    assign s1_free = !s1_valid_reg || s2_free;

    always_comb
    begin
        phase_next    = phase_reg;
        counter_next  = counter_reg;
        if (load)
        begin
            phase_next = phase_reg + PHASE_BITS'(cfg.phase_step);
            if (cnt_inc >= {1'b0, cfg.period_count})
            begin
                counter_next = '0;
            end
            else
            begin
                counter_next = cnt_inc[CNT_BITS-1:0];
            end
        end
        s1_valid_next = s1_free ? load : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            counter_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            counter_reg  <= counter_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ctrl_reg.quad        <= quad;
            s1_ctrl_reg.full_scale  <= quad[0] && (addr == '0);
            s1_ctrl_reg.square_high <= counter_reg <= cfg.high_limit;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_ctrl_reg))
        else $error("stage one lost its beat while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ctrl_reg.full_scale |-> s1_ctrl_reg.quad[0])
        else $error("full scale flagged outside a mirrored quadrant");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> counter_reg < $past(cfg.period_count) || counter_reg == '0)
        else $error("period counter passed its wrap point");

endmodule

// ===== rtl/core/att_sample_fmt.sv =====
// amplitude multiply, waveform select, word format and output register
module att_sample_fmt
    import att_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 s1_valid,
    input  stage_ctrl_t          s1_ctrl,
    input  logic [SINE_BITS-1:0] rom_data,
    output logic                 s2_free,
    output logic                 pair_valid,
    input  logic                 pair_stall,
    output logic [WORD_BITS-1:0] left_word,
    output logic [WORD_BITS-1:0] right_word,
    output logic                 right_present
);

    logic [SINE_BITS-1:0] mag;
    logic [PROD_BITS-1:0] prod_full;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic [AMP_BITS-1:0]  s2_prod_reg;
    logic                 s2_neg_reg;
    logic                 s2_square_high_reg;
    logic                 pair_valid_reg;
    logic                 pair_valid_next;
    logic [WORD_BITS-1:0] left_word_reg;
    logic [WORD_BITS-1:0] right_word_reg;
    logic                 right_present_reg;
    logic                 out_take;
    logic                 en2;
    logic [VAL_BITS-1:0]  signed_val;
    logic [VAL_BITS-1:0]  offset_val;
    logic [VAL_BITS-1:0]  val;
    logic [WORD_BITS-1:0] word;

    assign mag       = s1_ctrl.full_scale ? FULL_SCALE : rom_data;
    assign prod_full = PROD_BITS'(mag) * PROD_BITS'(cfg.amplitude);

    assign out_take = !pair_valid_reg || !pair_stall;
    assign s2_free  = !s2_valid_reg || out_take;
    assign en2      = s1_valid && s2_free;

    always_comb
    begin
        s2_valid_next   = s2_free ? s1_valid : s2_valid_reg;
        pair_valid_next = out_take ? s2_valid_reg : pair_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg   <= s2_valid_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_prod_reg        <= prod_full[PROD_BITS-1 -: AMP_BITS];
            s2_neg_reg         <= s1_ctrl.quad[1];
            s2_square_high_reg <= s1_ctrl.square_high;
        end
    end

    always_comb
    begin
        signed_val = s2_neg_reg ? ('0 - {1'b0, s2_prod_reg}) : {1'b0, s2_prod_reg};
        offset_val = cfg.unsigned_mode ? signed_val + {1'b0, cfg.amplitude} : signed_val;
        if (cfg.square_mode)
        begin
            val = s2_square_high_reg ? {cfg.amplitude, 1'b0} : '0;
        end
        else
        begin
            val = offset_val;
        end
        if (cfg.wide_samples)
        begin
            word = {val, WIDE_SHIFT'(0)};
        end
        else
        begin
            word = WORD_BITS'(val[NARROW_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_take)
        begin
            left_word_reg     <= (cfg.channel_mode == CH_LEFT_MUTE) ? '0 : word;
            right_word_reg    <= (cfg.channel_mode == CH_RIGHT_MUTE ||
                                  cfg.channel_mode == CH_MONO) ? '0 : word;
            right_present_reg <= cfg.channel_mode != CH_MONO;
        end
    end

    assign pair_valid    = pair_valid_reg;
    assign left_word     = left_word_reg;
    assign right_word    = right_word_reg;
    assign right_present = right_present_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_take |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("stage two lost its beat while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid_reg && cfg.channel_mode == CH_STEREO |-> left_word_reg == right_word_reg)
        else $error("stereo channels differ");

    assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid_reg && !cfg.wide_samples |->
            left_word_reg[WORD_BITS-1:NARROW_BITS] == '0 &&
            right_word_reg[WORD_BITS-1:NARROW_BITS] == '0)
        else $error("narrow sample has upper bits set");

endmodule

// ===== rtl/core/audio_test_tone_generator.sv =====
// top level of the audio test-tone generator
// a tick beat on tick_valid/tick_stall with sample_request high produces one
// stereo sample pair on pair_valid/pair_stall; a tick with sample_request low
// is taken and dropped without touching the phase or the period counter.
// registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong in idle time only.
// a taken tick passes the registered table read, the registered amplitude
// multiply and the word format into the output register, in that order.
// throughput: one pair per cycle while pair_stall is low; the table sits in a
// registered rom with one read port and the 23x23 multiply is registered, so
// each stage takes a beat every cycle unless the stage ahead of it holds.
// when the receiver stalls, the output register holds its pair and the two
// stages behind it keep filling; tick_stall rises only once all three hold
// beats.
// reset clears the phase accumulator and period counter and loads the default
// registers (800 hz at 44.1 khz, 16-bit signed stereo sine); no clearing
// pass is needed, ticks are taken right after reset.
module audio_test_tone_generator
    import att_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    output logic                     tick_stall,
    input  logic                     sample_request,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     pair_valid,
    input  logic                     pair_stall,
    output logic [WORD_BITS-1:0]     left_word,
    output logic [WORD_BITS-1:0]     right_word,
    output logic                     right_present
);

    cfg_t                       cfg;
    logic                       load;
    logic                       s1_valid;
    stage_ctrl_t                s1_ctrl;
    logic                       s2_free;
    logic                       rom_en;
    logic [TABLE_ADDR_BITS-1:0] rom_addr;
    logic [SINE_BITS-1:0]       rom_data;

    assign tick_stall = s1_valid && !s2_free;
    assign load       = tick_valid && !tick_stall && sample_request;

    att_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    att_phase_gen u_phase_gen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .load     (load),
        .s2_free  (s2_free),
        .s1_valid (s1_valid),
        .s1_ctrl  (s1_ctrl),
        .rom_en   (rom_en),
        .rom_addr (rom_addr)
    );

    att_sine_rom u_sine_rom
    (
        .clk     (clk),
        .rd_en   (rom_en),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    att_sample_fmt u_sample_fmt
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s1_valid      (s1_valid),
        .s1_ctrl       (s1_ctrl),
        .rom_data      (rom_data),
        .s2_free       (s2_free),
        .pair_valid    (pair_valid),
        .pair_stall    (pair_stall),
        .left_word     (left_word),
        .right_word    (right_word),
        .right_present (right_present)
    );

endmodule

// ===== sim/tone_pair_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the audio test-tone generator: predicts every sample pair and checks it
module tone_pair_checker
    import att_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    input  logic                     tick_stall,
    input  logic                     sample_request,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     pair_valid,
    input  logic                     pair_stall,
    input  logic [WORD_BITS-1:0]     left_word,
    input  logic [WORD_BITS-1:0]     right_word,
    input  logic                     right_present,
    output int                       mismatches,
    output int                       outstanding
);

    localparam logic [STEP_BITS-1:0] DEFAULT_STEP   = 32'd77913239;
    localparam logic [CNT_BITS-1:0]  DEFAULT_PERIOD = 16'd56;
    localparam logic [CNT_BITS-1:0]  DEFAULT_HIGH   = 16'd27;
    localparam logic [AMP_BITS-1:0]  DEFAULT_AMP    = 23'd32767;
    localparam logic [63:0]          QUARTER_TURN   = 64'd1686629713;
    localparam logic [63:0]          PEAK           = 64'd8388607;
    localparam int                   SERIES_TERMS   = 7;
    localparam int                   REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;
        logic                 right_present;
    } tone_pair_t;

    logic [SINE_BITS-1:0]  quarter_sine [TABLE_SIZE];
    cfg_t                  settings;
    logic [PHASE_BITS-1:0] phase;
    logic [CNT_BITS-1:0]   period_pos;
    tone_pair_t            expected_pairs [$];
    int                    mismatch_count = 0;

    // quarter-wave table in q0.23 from a truncated series in q.30
    initial
    begin : fill_quarter_sine
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      series;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            x      = (QUARTER_TURN * 64'(i)) >> TABLE_ADDR_BITS;
            x2     = (x * x) >> 30;
            term   = x;
            series = longint'(x);
            for (int k = 1; k <= SERIES_TERMS; k++)
            begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    series = series - longint'(term);
                else
                    series = series + longint'(term);
            end
            if (series < 0)
                series = 0;
            rounded = (64'(series) + 64'd64) >> 7;
            if (rounded > PEAK)
                rounded = PEAK;
            quarter_sine[i] = rounded[SINE_BITS-1:0];
        end
    end

    function automatic tone_pair_t tone_pair_at(input logic [PHASE_BITS-1:0] ph,
                                                input logic [CNT_BITS-1:0] pos,
                                                input cfg_t s);
        logic [1:0]                 quadrant;
        logic [TABLE_ADDR_BITS-1:0] idx;
        logic [63:0]                mag;
        logic [63:0]                scaled;
        logic [63:0]                level;
        logic [63:0]                word;
        tone_pair_t                 p;
        quadrant = ph[PHASE_BITS-1 -: 2];
        idx      = ph[ADDR_SHIFT +: TABLE_ADDR_BITS];
        if (!quadrant[0])
            mag = 64'(quarter_sine[idx]);
        else if (idx == '0)
            mag = PEAK;
        else
            mag = 64'(quarter_sine[TABLE_SIZE - int'(idx)]);
        scaled = (mag * 64'(s.amplitude)) >> SINE_BITS;
        level  = quadrant[1] ? (64'd0 - scaled) : scaled;
        if (s.unsigned_mode)
            level = level + 64'(s.amplitude);
        if (s.square_mode)
            level = (pos <= s.high_limit) ? (64'(s.amplitude) << 1) : 64'd0;
        if (s.wide_samples)
            word = level << WIDE_SHIFT;
        else
            word = 64'(level[NARROW_BITS-1:0]);
        p.left_word     = (s.channel_mode == CH_LEFT_MUTE) ? '0 : word[WORD_BITS-1:0];
        p.right_word    = (s.channel_mode == CH_RIGHT_MUTE || s.channel_mode == CH_MONO) ?
                          '0 : word[WORD_BITS-1:0];
        p.right_present = (s.channel_mode != CH_MONO);
        return p;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tone_pair_checker: %s expected %h got %h at %0t", what, want, got, $time);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tone_pair_t          want;
        logic [CNT_BITS:0]   next_pos;
        if (!rst_n)
        begin
            settings.phase_step    = DEFAULT_STEP;
            settings.period_count  = DEFAULT_PERIOD;
            settings.high_limit    = DEFAULT_HIGH;
            settings.amplitude     = DEFAULT_AMP;
            settings.unsigned_mode = 1'b0;
            settings.square_mode   = 1'b0;
            settings.wide_samples  = 1'b0;
            settings.channel_mode  = CH_STEREO;
            phase                  = '0;
            period_pos             = '0;
            expected_pairs.delete();
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("tone_pair_checker: unexpected pair left %h right %h at %0t",
                                 left_word, right_word, $time);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (left_word !== want.left_word)
                        note_mismatch("left_word", 64'(want.left_word), 64'(left_word));
                    if (right_word !== want.right_word)
                        note_mismatch("right_word", 64'(want.right_word), 64'(right_word));
                    if (right_present !== want.right_present)
                        note_mismatch("right_present", 64'(want.right_present),
                                      64'(right_present));
                end
            end
            if (tick_valid && !tick_stall && sample_request)
            begin
                expected_pairs.push_back(tone_pair_at(phase, period_pos, settings));
                phase    = phase + settings.phase_step;
                next_pos = {1'b0, period_pos} + 1'b1;
                if (next_pos >= {1'b0, settings.period_count})
                    period_pos = '0;
                else
                    period_pos = next_pos[CNT_BITS-1:0];
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_PHASE_STEP:    settings.phase_step    = cfg_data[STEP_BITS-1:0];
                    REG_PERIOD_COUNT:  settings.period_count  = cfg_data[CNT_BITS-1:0];
                    REG_HIGH_LIMIT:    settings.high_limit    = cfg_data[CNT_BITS-1:0];
                    REG_AMPLITUDE:     settings.amplitude     = cfg_data[AMP_BITS-1:0];
                    REG_UNSIGNED_MODE: settings.unsigned_mode = cfg_data[0];
                    REG_SQUARE_MODE:   settings.square_mode   = cfg_data[0];
                    REG_WIDE_SAMPLES:  settings.wide_samples  = cfg_data[0];
                    REG_CHANNEL_MODE:  settings.channel_mode  = chan_mode_t'(cfg_data[1:0]);
                    default:           ;
                endcase
            end
        end
        mismatches  <= mismatch_count;
        outstanding <= expected_pairs.size();
    end

endmodule

// ===== sim/tb_audio_test_tone_generator.sv =====
`timescale 1ns / 100ps
// testbench top for the audio test-tone generator: clock, reset, tick and register stimulus
module tb_audio_test_tone_generator;
    import att_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REG_COUNT       = 1 << CFG_IDX_BITS;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     tick_valid;
    logic                     tick_stall;
    logic                     sample_request;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     pair_valid;
    logic                     pair_stall;
    logic [WORD_BITS-1:0]     left_word;
    logic [WORD_BITS-1:0]     right_word;
    logic                     right_present;
    int                       mismatches;
    int                       outstanding;
    int                       requests_sent;
    stall_style_t             stall_style;
    int                       stall_left;

    audio_test_tone_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .sample_request (sample_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pair_valid     (pair_valid),
        .pair_stall     (pair_stall),
        .left_word      (left_word),
        .right_word     (right_word),
        .right_present  (right_present)
    );

    tone_pair_checker pair_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .sample_request (sample_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pair_valid     (pair_valid),
        .pair_stall     (pair_stall),
        .left_word      (left_word),
        .right_word     (right_word),
        .right_present  (right_present),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure, switching between styles of stalling
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            stall_left  <= $urandom_range(5, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            STALL_NONE:  pair_stall <= 1'b0;
            STALL_HALF:  pair_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: pair_stall <= ($urandom_range(0, 3) != 0);
            default:     pair_stall <= ~pair_stall;
        endcase
    end

    task automatic wait_drained();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s, input bit noisy);
        logic [CFG_DATA_BITS-1:0] value [REG_COUNT];
        logic [CFG_DATA_BITS-1:0] keep [REG_COUNT];
        value[REG_PHASE_STEP]    = s.phase_step;
        value[REG_PERIOD_COUNT]  = 32'(s.period_count);
        value[REG_HIGH_LIMIT]    = 32'(s.high_limit);
        value[REG_AMPLITUDE]     = 32'(s.amplitude);
        value[REG_UNSIGNED_MODE] = 32'(s.unsigned_mode);
        value[REG_SQUARE_MODE]   = 32'(s.square_mode);
        value[REG_WIDE_SAMPLES]  = 32'(s.wide_samples);
        value[REG_CHANNEL_MODE]  = 32'(s.channel_mode);
        keep[REG_PHASE_STEP]     = '1;
        keep[REG_PERIOD_COUNT]   = (32'd1 << CNT_BITS) - 1;
        keep[REG_HIGH_LIMIT]     = (32'd1 << CNT_BITS) - 1;
        keep[REG_AMPLITUDE]      = (32'd1 << AMP_BITS) - 1;
        keep[REG_UNSIGNED_MODE]  = 32'd1;
        keep[REG_SQUARE_MODE]    = 32'd1;
        keep[REG_WIDE_SAMPLES]   = 32'd1;
        keep[REG_CHANNEL_MODE]   = 32'd3;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[CFG_IDX_BITS-1:0];
            cfg_data  <= noisy ? (value[i] | ($urandom() & ~keep[i])) : value[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // sends ticks in bursts; idle_pct of them carry no request
    task automatic run_ticks(input int count, input int idle_pct);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
                else
                begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                    begin
                        tick_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            burst--;
            tick_valid     <= 1'b1;
            sample_request <= ($urandom_range(0, 99) >= idle_pct);
            do
                @(posedge clk);
            while (tick_stall);
            if (sample_request)
                requests_sent++;
        end
    endtask

    function automatic cfg_t settings_of(input logic [STEP_BITS-1:0] step,
                                         input logic [CNT_BITS-1:0] period,
                                         input logic [CNT_BITS-1:0] high,
                                         input logic [AMP_BITS-1:0] amp,
                                         input bit as_unsigned, input bit square,
                                         input bit wide, input chan_mode_t chan);
        cfg_t s;
        s.phase_step    = step;
        s.period_count  = period;
        s.high_limit    = high;
        s.amplitude     = amp;
        s.unsigned_mode = as_unsigned;
        s.square_mode   = square;
        s.wide_samples  = wide;
        s.channel_mode  = chan;
        return s;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        case ($urandom_range(0, 4))
            0:       s.phase_step = '0;
            1:       s.phase_step = '1;
            2:       s.phase_step = $urandom_range(1, 32'h0400_0000);
            default: s.phase_step = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       s.period_count = '0;
            1:       s.period_count = '1;
            default: s.period_count = CNT_BITS'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 4))
            0:       s.high_limit = '0;
            1:       s.high_limit = '1;
            default: s.high_limit = CNT_BITS'($urandom_range(0, s.period_count));
        endcase
        case ($urandom_range(0, 4))
            0:       s.amplitude = '0;
            1:       s.amplitude = '1;
            default: s.amplitude = AMP_BITS'($urandom_range(0, (1 << AMP_BITS) - 1));
        endcase
        s.unsigned_mode = 1'($urandom_range(0, 1));
        s.square_mode   = 1'($urandom_range(0, 1));
        s.wide_samples  = 1'($urandom_range(0, 1));
        s.channel_mode  = chan_mode_t'($urandom_range(0, 3));
        return s;
    endfunction

    initial
    begin
        #2_000_000;
        $display("tb_audio_test_tone_generator: done, errors");
        $finish;
    end

    initial
    begin
        int goal;
        rst_n          = 1'b0;
        tick_valid     = 1'b0;
        sample_request = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pair_stall     = 1'b0;
        stall_style    = STALL_NONE;
        stall_left     = 0;
        requests_sent  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, a tick without request first
        run_ticks(1, 100);
        run_ticks(2, 0);
        // quarter steps land on every quadrant boundary
        wait_drained();
        load_settings(settings_of(32'h4000_0000, 16'd56, 16'd27, '1,
                                  1'b0, 1'b0, 1'b0, CH_STEREO), 1'b0);
        run_ticks(5, 0);
        wait_drained();
        load_settings(settings_of('1, 16'd56, 16'd27, '1,
                                  1'b1, 1'b0, 1'b1, CH_LEFT_MUTE), 1'b0);
        run_ticks(3, 0);
        // zero period count behaves as one
        wait_drained();
        load_settings(settings_of(32'h0800_0000, '0, '0, '1,
                                  1'b0, 1'b1, 1'b1, CH_RIGHT_MUTE), 1'b0);
        run_ticks(3, 0);
        wait_drained();
        load_settings(settings_of(32'h1234_5679, 16'd3, 16'd1, 23'h40_0000,
                                  1'b0, 1'b1, 1'b0, CH_MONO), 1'b0);
        run_ticks(5, 0);
        wait_drained();
        load_settings(settings_of('0, '1, '1, '0,
                                  1'b1, 1'b0, 1'b0, CH_STEREO), 1'b0);
        run_ticks(2, 0);
        wait_drained();
        load_settings(settings_of(32'h2000_0000, '1, '1, '1,
                                  1'b1, 1'b1, 1'b0, CH_STEREO), 1'b1);
        run_ticks(3, 0);

        goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < goal)
        begin
            wait_drained();
            load_settings(random_settings(), 1'($urandom_range(0, 1)));
            run_ticks($urandom_range(40, 160), 8);
        end
        wait_drained();

        if (mismatches == 0 && outstanding == 0)
            $display("tb_audio_test_tone_generator: done, clean");
        else
            $display("tb_audio_test_tone_generator: done, errors");
        $finish;
    end

endmodule
